/* rtl/bmw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_pkg: shared types and constants for the multiway tree priority queue
// Holds the request/response payload structs and the controller/datapath link.
// ----------------------------------------------------------------------------
package bmw_pkg;

   localparam int TREE_COUNT_DEF  = 8;
   localparam int TREE_LEVELS_DEF = 4;
   localparam int RANK_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF  = 16;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  tree_id;
      logic [31:0] push_rank;
      logic [15:0] push_value;
   } req_type_type;

   typedef struct packed {
      logic [31:0] pop_rank;
      logic [15:0] pop_value;
      logic        pop_valid;
      logic        push_dropped;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // capture request, start at root
      logic rd;        // issue read of current node
      logic step;      // apply one level with the read data
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic done;      // walk finished, result registered
      logic clearing;  // node store sweep after reset in progress
   } sts_type;

endpackage

/* rtl/bmw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_ctrl: request sequencer
// Walks a request through read and update phases, one tree level per pair.
// ----------------------------------------------------------------------------
module bmw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output bmw_pkg::cmd_type cmd,
   input  bmw_pkg::sts_type sts
);
   import bmw_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_STEP
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: if (start && !sts.clearing) state_ff <= ST_READ;
            ST_READ: state_ff <= ST_STEP;
            ST_STEP: state_ff <= sts.done ? ST_IDLE : ST_READ;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE) || sts.clearing;
   assign cmd.load  = (state_ff == ST_IDLE) && start && !sts.clearing;
   assign cmd.rd    = (state_ff == ST_READ);
   assign cmd.step  = (state_ff == ST_STEP);

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_READ) else $error("load did not start walk");
   a_step_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> cmd.step) else $error("read not followed by step");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.done) |=> !busy) else $error("done did not idle");

endmodule

/* rtl/bmw_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_dpath: node memory and per-level update
// Node store with one read and one write port, fill counters, result register.
// ----------------------------------------------------------------------------
module bmw_dpath #(
   parameter int TREE_COUNT  = bmw_pkg::TREE_COUNT_DEF,
   parameter int TREE_LEVELS = bmw_pkg::TREE_LEVELS_DEF,
   parameter int RANK_BITS   = bmw_pkg::RANK_BITS_DEF,
   parameter int VALUE_BITS  = bmw_pkg::VALUE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bmw_pkg::req_type_type req,
   input  bmw_pkg::cmd_type     cmd,
   output bmw_pkg::sts_type     sts,
   output logic                 rsp_strobe,
   output bmw_pkg::rsp_type     rsp
);
   import bmw_pkg::*;

   localparam int NODES   = (1 << TREE_LEVELS) - 1;
   localparam int CAP     = 2 * NODES;
   localparam int DEPTH   = TREE_COUNT * NODES;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW      = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int TW      = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
   localparam int FW      = $clog2(CAP + 1);
   localparam int CW      = $clog2(NODES + 1);
   localparam int LW      = $clog2(TREE_LEVELS + 1);

   typedef struct packed {
      logic                  vld;
      logic [RANK_BITS-1:0]  rank;
      logic [VALUE_BITS-1:0] value;
      logic [CW-1:0]         cnt;
   } slot_type;

   typedef struct packed {
      slot_type s1;
      slot_type s0;
   } node_type;

   // node memory, cleared by a sweep after reset
   node_type mem [DEPTH];
   node_type rd_ff;
   logic [AW-1:0] clr_ff;
   logic          clr_busy_ff;

   logic [FW-1:0] fill_ff [TREE_COUNT];

   logic                  op_ff;
   logic [TW-1:0]         tree_ff;
   logic                  tree_ok_ff;
   logic [RANK_BITS-1:0]  rank_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [NW-1:0]         node_ff;
   logic [LW-1:0]         lvl_ff;
   logic                  d_ff;      // pop: slot hole at current node
   logic                  first_ff;  // pop: root level

   rsp_type rsp_ff;
   logic    strobe_ff;

   logic [AW-1:0] base_addr;
   assign base_addr = AW'(tree_ff) * AW'(NODES);

   // step logic
   node_type wr_node;
   logic     wr_en;
   logic     fin;
   logic [NW-1:0] node_next;
   logic     d_next;
   logic [RANK_BITS-1:0]  rank_next;
   logic [VALUE_BITS-1:0] value_next;
   logic     out_valid;
   logic [RANK_BITS-1:0]  out_rank;
   logic [VALUE_BITS-1:0] out_value;
   node_type tail_node;

   function automatic logic less(input logic [RANK_BITS-1:0] ra,
                                 input logic [VALUE_BITS-1:0] va,
                                 input logic [RANK_BITS-1:0] rb,
                                 input logic [VALUE_BITS-1:0] vb);
      return (ra < rb) || (ra == rb && va < vb);
   endfunction

   function automatic logic pick(input node_type n);
      logic r;
      if (!n.s0.vld) r = n.s1.vld;
      else if (!n.s1.vld) r = 1'b0;
      else r = less(n.s1.rank, n.s1.value, n.s0.rank, n.s0.value);
      return r;
   endfunction

   logic full_tree;
   assign full_tree = (fill_ff[tree_ff] >= FW'(CAP));

   // the walk keeps the parent node in par_ff for pop refills
   node_type       par_ff;
   logic [NW-1:0]  par_idx_ff;
   logic [AW-1:0]  wr_addr;
   logic [NW-1:0]  child;
   slot_type       ps, cs;
   logic           cd;

   always_comb begin
      wr_node    = rd_ff;
      wr_en      = 1'b0;
      wr_addr    = base_addr + AW'(node_ff);
      fin        = 1'b0;
      node_next  = node_ff;
      d_next     = d_ff;
      rank_next  = rank_ff;
      value_next = value_ff;
      out_valid  = 1'b0;
      out_rank   = '0;
      out_value  = '0;
      child      = '0;
      ps         = '0;
      cs         = '0;
      cd         = 1'b0;
      if (!tree_ok_ff) begin
         fin = 1'b1;
      end else if (op_ff == REQ_PUSH) begin
         if (full_tree) begin
            fin = 1'b1;
         end else if (!rd_ff.s0.vld) begin
            wr_en = 1'b1; fin = 1'b1;
            wr_node.s0.vld = 1'b1; wr_node.s0.rank = rank_ff; wr_node.s0.value = value_ff;
         end else if (!rd_ff.s1.vld) begin
            wr_en = 1'b1; fin = 1'b1;
            wr_node.s1.vld = 1'b1; wr_node.s1.rank = rank_ff; wr_node.s1.value = value_ff;
         end else if (32'(lvl_ff) + 1 >= TREE_LEVELS) begin
            fin = 1'b1;
         end else begin
            cd = (rd_ff.s0.cnt > rd_ff.s1.cnt);
            ps = cd ? rd_ff.s1 : rd_ff.s0;
            if (less(rank_ff, value_ff, ps.rank, ps.value)) begin
               rank_next  = ps.rank;  value_next = ps.value;
               ps.rank    = rank_ff;  ps.value   = value_ff;
            end
            ps.cnt = ps.cnt + CW'(1);
            if (cd) wr_node.s1 = ps; else wr_node.s0 = ps;
            wr_en = 1'b1;
            node_next = NW'(2 * 32'(node_ff) + 1 + 32'(cd));
         end
      end else begin
         if (first_ff) begin
            // root: choose victim, report it
            cd = pick(rd_ff);
            ps = cd ? rd_ff.s1 : rd_ff.s0;
            if (!ps.vld) begin
               fin = 1'b1;
            end else begin
               out_valid = 1'b1; out_rank = ps.rank; out_value = ps.value;
               d_next = cd;
               if (32'(lvl_ff) + 1 < TREE_LEVELS && ps.cnt != '0) begin
                  node_next = NW'(2 * 32'(node_ff) + 1 + 32'(cd));
               end else begin
                  ps = '0;
                  if (cd) wr_node.s1 = ps; else wr_node.s0 = ps;
                  wr_en = 1'b1; fin = 1'b1;
               end
            end
         end else begin
            // rd_ff is the child of par_ff's slot d_ff
            cd = pick(rd_ff);
            cs = cd ? rd_ff.s1 : rd_ff.s0;
            wr_node = par_ff;
            wr_addr = base_addr + AW'(par_idx_ff);
            wr_en   = 1'b1;
            ps = d_ff ? par_ff.s1 : par_ff.s0;
            if (cs.vld) begin
               ps.rank = cs.rank; ps.value = cs.value; ps.cnt = ps.cnt - CW'(1);
               d_next = cd;
               child = NW'(2 * 32'(node_ff) + 1 + 32'(cd));
               if (32'(lvl_ff) + 1 < TREE_LEVELS && cs.cnt != '0) begin
                  node_next = child;
               end else begin
                  fin = 1'b1;  // child slot gets cleared by the tail write
               end
            end else begin
               ps = '0; fin = 1'b1;
            end
            if (d_ff) wr_node.s1 = ps; else wr_node.s0 = ps;
         end
      end
      tail_node = rd_ff;
      if (cd) tail_node.s1 = '0; else tail_node.s0 = '0;
   end

   // pop tail: child slot emptied in the cycle after its parent refill
   logic          tail_ff;
   logic [AW-1:0] tail_addr_ff;
   node_type      tail_node_ff;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (tail_ff) begin
         mem[tail_addr_ff] <= tail_node_ff;
      end else if (cmd.step && wr_en) begin
         mem[wr_addr] <= wr_node;
      end
      if (cmd.rd) rd_ff <= mem[base_addr + AW'(node_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
         tail_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
         for (int i = 0; i < TREE_COUNT; i++) fill_ff[i] <= '0;
      end else begin
         strobe_ff <= 1'b0;
         tail_ff   <= 1'b0;
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + AW'(1);
            if (32'(clr_ff) == DEPTH - 1) clr_busy_ff <= 1'b0;
         end
         if (cmd.step) begin
            if (op_ff == REQ_POP && !first_ff && tree_ok_ff && fin &&
                (cd ? rd_ff.s1.vld : rd_ff.s0.vld)) begin
               tail_ff <= 1'b1;
            end
            if (fin) begin
               strobe_ff <= 1'b1;
               if (tree_ok_ff && op_ff == REQ_PUSH && !full_tree)
                  fill_ff[tree_ff] <= fill_ff[tree_ff] + FW'(1);
               if (tree_ok_ff && op_ff == REQ_POP
                   && (first_ff ? out_valid : rsp_ff.pop_valid)
                   && fill_ff[tree_ff] != '0)
                  fill_ff[tree_ff] <= fill_ff[tree_ff] - FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else if (cmd.load) begin
         op_ff      <= req.req_type;
         tree_ok_ff <= (32'(req.tree_id) < TREE_COUNT);
         tree_ff    <= TW'(req.tree_id);
         rank_ff    <= RANK_BITS'(req.push_rank);
         value_ff   <= VALUE_BITS'(req.push_value);
         node_ff    <= '0;
         lvl_ff     <= '0;
         first_ff   <= 1'b1;
         rsp_ff     <= '0;
      end else if (cmd.step) begin
         if (first_ff && out_valid) begin
            rsp_ff.pop_valid <= 1'b1;
            rsp_ff.pop_rank  <= 32'(out_rank);
            rsp_ff.pop_value <= 16'(out_value);
         end
         if (fin && op_ff == REQ_PUSH && (!tree_ok_ff || full_tree))
            rsp_ff.push_dropped <= 1'b1;
         if (op_ff == REQ_POP) first_ff <= 1'b0;
         // the node just read, unchanged so far, is the parent of the next refill
         par_ff       <= rd_ff;
         par_idx_ff   <= node_ff;
         node_ff      <= node_next;
         d_ff         <= d_next;
         rank_ff      <= rank_next;
         value_ff     <= value_next;
         lvl_ff       <= lvl_ff + LW'(1);
         // tail clears the last child slot
         tail_addr_ff <= base_addr + AW'(node_ff);
         tail_node_ff <= tail_node;
      end
   end

   assign sts.done     = fin;
   assign sts.clearing = clr_busy_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp          = rsp_ff;

   a_no_wr_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !cmd.step) else $error("walk during clear sweep");
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff) else $error("double result");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ff.pop_valid && rsp_ff.push_dropped)) else $error("both flags");

endmodule

/* rtl/bmw_tree_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_tree_priority_queue_top: banked 2-ary multiway tree priority queue
// Push and pop requests over a bank of independent trees in one node memory.
// ----------------------------------------------------------------------------
// Each request takes a read and an update step per tree level it walks:
// a request that walks k levels (at most TREE_LEVELS) puts its single
// rsp_strobe beat out after its last update step. busy stays high through that
// result cycle, so the next request is accepted only after that beat has gone.
// After reset a clearing pass over all TREE_COUNT*(2^TREE_LEVELS-1) nodes runs
// with busy high.
// The receiver cannot stall, so results must be taken when strobed.
module bmw_tree_priority_queue_top #(
   parameter int TREE_COUNT  = bmw_pkg::TREE_COUNT_DEF,
   parameter int TREE_LEVELS = bmw_pkg::TREE_LEVELS_DEF,
   parameter int RANK_BITS   = bmw_pkg::RANK_BITS_DEF,
   parameter int VALUE_BITS  = bmw_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bmw_pkg::req_type_type req_data,
   output logic                  rsp_strobe,
   output bmw_pkg::rsp_type      rsp_data
);
   import bmw_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    ctrl_busy;
   logic    dp_strobe;

   bmw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start && !busy),
      .busy  (ctrl_busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   bmw_dpath #(
      .TREE_COUNT  (TREE_COUNT),
      .TREE_LEVELS (TREE_LEVELS),
      .RANK_BITS   (RANK_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (dp_strobe),
      .rsp        (rsp_data)
   );

   // hold off requests until the result beat of the previous one has gone
   assign busy       = ctrl_busy || dp_strobe;
   assign rsp_strobe = dp_strobe;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the banked multiway tree priority queue
// Drives push and pop beats against a behavioral tree bank and compares every
// response field by field, with random gaps between requests outside the full-tree tests.
// ----------------------------------------------------------------------------
module tb;
   import bmw_pkg::*;

   localparam int TREES    = 8;
   localparam int LEVELS   = 4;
   localparam int NODES    = (1 << LEVELS) - 1;
   localparam int CAPACITY = 2 * NODES;
   localparam int SLOTS    = TREES * NODES * 2;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   // behavioral tree bank
   logic        slot_full [SLOTS];
   logic [31:0] slot_rank [SLOTS];
   logic [15:0] slot_val [SLOTS];
   int unsigned slot_below [SLOTS];
   int unsigned fill_of [TREES];

   rsp_type pending_rsp[$];
   int errors = 0;
   int cycles = 0;

   bmw_tree_priority_queue_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic bit entry_lt(logic [31:0] ra, logic [15:0] va,
                                   logic [31:0] rb, logic [15:0] vb);
      return (ra < rb) || (ra == rb && va < vb);
   endfunction

   function automatic int smaller_slot(int b);
      if (!slot_full[b]) return slot_full[b+1] ? 1 : 0;
      if (!slot_full[b+1]) return 0;
      return entry_lt(slot_rank[b+1], slot_val[b+1], slot_rank[b], slot_val[b]) ? 1 : 0;
   endfunction

   function automatic bit tree_insert(int t, logic [31:0] r, logic [15:0] v);
      int n, b, d, s;
      logic [31:0] tr;
      logic [15:0] tv;
      n = 0;
      if (fill_of[t] >= CAPACITY) return 1'b0;
      fill_of[t]++;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         b = (t * NODES + n) * 2;
         if (!slot_full[b] || !slot_full[b+1]) begin
            s = slot_full[b] ? b + 1 : b;
            slot_full[s] = 1'b1;
            slot_rank[s] = r;
            slot_val[s] = v;
            return 1'b1;
         end
         if (lvl + 1 >= LEVELS) break;
         d = (slot_below[b] > slot_below[b+1]) ? 1 : 0;
         s = b + d;
         if (entry_lt(r, v, slot_rank[s], slot_val[s])) begin
            tr = slot_rank[s];
            tv = slot_val[s];
            slot_rank[s] = r;
            slot_val[s] = v;
            r = tr;
            v = tv;
         end
         slot_below[s]++;
         n = 2 * n + 1 + d;
      end
      return 1'b1;
   endfunction

   function automatic bit tree_extract(int t, output logic [31:0] r,
                                       output logic [15:0] v);
      int n, lvl, b, d, s, c, cb, cd;
      n = 0;
      lvl = 0;
      b = t * NODES * 2;
      d = smaller_slot(b);
      r = '0;
      v = '0;
      if (!slot_full[b+d]) return 1'b0;
      r = slot_rank[b+d];
      v = slot_val[b+d];
      if (fill_of[t] > 0) fill_of[t]--;
      forever begin
         s = b + d;
         if (lvl + 1 < LEVELS && slot_below[s] > 0) begin
            c = 2 * n + 1 + d;
            cb = (t * NODES + c) * 2;
            cd = smaller_slot(cb);
            if (slot_full[cb+cd]) begin
               slot_rank[s] = slot_rank[cb+cd];
               slot_val[s] = slot_val[cb+cd];
               slot_below[s]--;
               n = c;
               b = cb;
               d = cd;
               lvl++;
               continue;
            end
         end
         slot_full[s] = 1'b0;
         slot_rank[s] = '0;
         slot_val[s] = '0;
         break;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type predict_rsp(req_type_type q);
      rsp_type e;
      logic [31:0] r;
      logic [15:0] v;
      e = '0;
      if (q.req_type == REQ_PUSH) begin
         e.push_dropped = !tree_insert(int'(q.tree_id), q.push_rank, q.push_value);
      end else begin
         e.pop_valid = tree_extract(int'(q.tree_id), r, v);
         e.pop_rank = r;
         e.pop_value = v;
      end
      return e;
   endfunction

   // send one beat after a random gap unless no_gap is set; predict once busy is seen low
   task automatic send_req(logic op, int t, logic [31:0] r, logic [15:0] v,
                           bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{req_type: op, tree_id: t[2:0], push_rank: r, push_value: v};
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_rsp(req_data));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response: actual %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.pop_rank !== e.pop_rank)
               $display("%0t pop_rank: expected %h actual %h", $time, e.pop_rank,
                        rsp_data.pop_rank);
            if (rsp_data.pop_value !== e.pop_value)
               $display("%0t pop_value: expected %h actual %h", $time, e.pop_value,
                        rsp_data.pop_value);
            if (rsp_data.pop_valid !== e.pop_valid)
               $display("%0t pop_valid: expected %b actual %b", $time, e.pop_valid,
                        rsp_data.pop_valid);
            if (rsp_data.push_dropped !== e.push_dropped)
               $display("%0t push_dropped: expected %b actual %b", $time,
                        e.push_dropped, rsp_data.push_dropped);
            if (rsp_data !== e) errors++;
         end
      end
   end

   function automatic logic [31:0] rand_rank();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 7);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_req(REQ_POP, 0, 32'hFFFF_FFFF, 16'hFFFF);        // empty tree
      send_req(REQ_PUSH, 0, 32'h0, 16'h0);
      send_req(REQ_PUSH, 0, 32'hFFFF_FFFF, 16'hFFFF);
      send_req(REQ_PUSH, 0, 32'h5, 16'h9);
      send_req(REQ_PUSH, 0, 32'h5, 16'h3);                   // rank tie
      send_req(REQ_PUSH, 7, 32'h1, 16'h1);
      for (int i = 0; i < 5; i++) send_req(REQ_POP, 0, '0, '0);
      send_req(REQ_POP, 7, '0, '0);
      send_req(REQ_POP, 7, '0, '0);
   endtask

   // fill one tree past capacity, then drain it past empty
   task automatic test_full_tree();
      int t;
      t = $urandom_range(0, TREES - 1);
      for (int i = 0; i < CAPACITY + 2; i++)
         send_req(REQ_PUSH, t, rand_rank(), 16'($urandom), 1);
      for (int i = 0; i < CAPACITY + 2; i++)
         send_req(REQ_POP, t, '0, '0, 1);
   endtask

   task automatic test_random(int count);
      int t;
      for (int i = 0; i < count; i++) begin
         t = $urandom_range(0, TREES - 1);
         if (fill_of[t] > CAPACITY - 4 && $urandom_range(0, 3) != 0)
            send_req(REQ_POP, t, $urandom, 16'($urandom));
         else
            send_req($urandom_range(0, 9) < 6 ? REQ_PUSH : REQ_POP, t,
                     rand_rank(), 16'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_full[i] = 0; slot_rank[i] = 0; slot_val[i] = 0; slot_below[i] = 0;
      end
      for (int i = 0; i < TREES; i++) fill_of[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_tree();
      test_random(1600);
      test_full_tree();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
